>>> rtl/core/abba_pkg.sv
// Shared types and constants for the ABBA-BABA window accumulator.
package abba_pkg;

    localparam int SUM_W = 64;

    typedef enum logic [2:0] {
        CLS_NO_INFO = 3'd0,
        CLS_P3_ZERO = 3'd1,
        CLS_AABA    = 3'd2,
        CLS_BBBA    = 3'd3,
        CLS_P1_EQ   = 3'd4,
        CLS_USED    = 3'd5,
        CLS_INDEL   = 3'd6
    } site_class_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_EMIT    = 2'd1,
        EV_DISCARD = 2'd2
    } window_event_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MUL1 = 2'd1,
        BK_MUL2 = 2'd2,
        BK_ACC  = 2'd3
    } back_state_t;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [SUM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
        if (s[SUM_W] != s[SUM_W-1]) begin
            sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sat_add = s[SUM_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/abba_front.sv
// Front end: accepts sites, clamps frequencies, classifies and queues them.
module abba_front import abba_pkg::*; #(
    parameter int FREQ_FRAC_BITS = 12,
    parameter int CHROM_WIDTH    = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [12:0]              s_p1_freq,
    input  logic [12:0]              s_p2_freq,
    input  logic [12:0]              s_p3_freq,
    input  logic                     s_no_info,
    input  logic                     s_is_indel,
    input  logic [15:0]              s_chrom_id,
    output logic                     q_valid,
    input  logic                     q_ready,
    output logic [FREQ_FRAC_BITS:0]  q_p1,
    output logic [FREQ_FRAC_BITS:0]  q_p2,
    output logic [FREQ_FRAC_BITS:0]  q_p3,
    output site_class_t              q_cls,
    output logic [CHROM_WIDTH-1:0]   q_chrom
);
    localparam int FW = FREQ_FRAC_BITS + 1;
    localparam logic [FW-1:0] ONE = FW'(1) << FREQ_FRAC_BITS;
    localparam int EW = 3 * FW + 3 + CHROM_WIDTH;

    logic [FW-1:0] p1, p2, p3;
    site_class_t cls;
    logic [EW-1:0] mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic wr_reg, wr_next, rd_reg, rd_next;
    logic push, pop;
    logic [CHROM_WIDTH-1:0] chrom;

    function automatic logic [FW-1:0] clampf(input logic [12:0] v);
        if ({{FW{1'b0}}, v} > {13'd0, ONE}) clampf = ONE;
        else clampf = FW'(v);
    endfunction

    assign p1 = clampf(s_p1_freq);
    assign p2 = clampf(s_p2_freq);
    assign p3 = clampf(s_p3_freq);
    assign chrom = CHROM_WIDTH'({16'd0, s_chrom_id});

    always_comb begin
        if (s_is_indel) cls = CLS_INDEL;
        else if (s_no_info) cls = CLS_NO_INFO;
        else if (p3 == '0) cls = CLS_P3_ZERO;
        else if (p1 == '0 && p2 == '0) cls = CLS_AABA;
        else if (p1 == ONE && p2 == ONE) cls = CLS_BBBA;
        else if (p1 == p2) cls = CLS_P1_EQ;
        else cls = CLS_USED;
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign push = s_valid && s_ready;
    assign pop = q_valid && q_ready;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    assign wr_next = wr_reg ^ push;
    assign rd_next = rd_reg ^ pop;
    assign {q_p1, q_p2, q_p3, q_cls, q_chrom} = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wr_reg <= 1'b0;
            rd_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            wr_reg <= wr_next;
            rd_reg <= rd_next;
        end
        if (push) mem_reg[wr_reg] <= {p1, p2, p3, cls, chrom};
    end

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> (wr_reg == rd_reg))
        else $error("queue pointers disagree with full count");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> (wr_reg == rd_reg))
        else $error("queue pointers disagree with empty count");
endmodule

>>> rtl/core/abba_back.sv
// Back end: forms the Q(3F) terms with parallel multipliers and accumulates sums.
module abba_back import abba_pkg::*; #(
    parameter int FREQ_FRAC_BITS = 12,
    parameter int CHROM_WIDTH    = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [15:0]              window_size,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  logic [FREQ_FRAC_BITS:0]  q_p1,
    input  logic [FREQ_FRAC_BITS:0]  q_p2,
    input  logic [FREQ_FRAC_BITS:0]  q_p3,
    input  site_class_t              q_cls,
    input  logic [CHROM_WIDTH-1:0]   q_chrom,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_site_class,
    output logic [1:0]               m_window_event,
    output logic signed [63:0]       m_win_d_num,
    output logic [62:0]              m_win_d_den,
    output logic signed [63:0]       m_win_fd_den,
    output logic signed [63:0]       m_win_fdm_den,
    output logic signed [63:0]       m_tot_d_num,
    output logic [62:0]              m_tot_d_den,
    output logic signed [63:0]       m_tot_fd_den,
    output logic signed [63:0]       m_tot_fdm_den,
    output logic signed [63:0]       m_tot_fg_num,
    output logic [62:0]              m_tot_fg_den
);
    localparam int FW = FREQ_FRAC_BITS + 1;
    localparam int PW = 2 * FW + 1;
    localparam int MW = PW + FW + 1;
    localparam logic [FW-1:0] ONE = FW'(1) << FREQ_FRAC_BITS;

    back_state_t state_reg, state_next;
    logic [FW-1:0] p1_reg, p2_reg, p3_reg;
    site_class_t cls_reg;
    logic [CHROM_WIDTH-1:0] chrom_reg;
    logic signed [PW-1:0] pa_reg, pb_reg, pc_reg, pd2_reg, pe_reg, pf_reg;
    logic signed [SUM_W-1:0] t_dn_reg, t_dd_reg, t_fd_reg, t_fm_reg;
    logic signed [SUM_W-1:0] win_reg [4];
    logic signed [SUM_W-1:0] tot_reg [6];
    logic [31:0] used_count_reg;
    logic [15:0] fill_reg;
    logic [CHROM_WIDTH-1:0] wchrom_reg;
    logic out_valid_reg;
    logic [2:0] o_cls_reg;
    logic [1:0] o_ev_reg;
    logic signed [SUM_W-1:0] o_win_reg [4];

    logic [FW-1:0] pdv, qv, n1, n2, npd, nq;
    logic accept, done, set_out;
    logic signed [SUM_W-1:0] nw [4];
    logic signed [MW-1:0] abba_m, baba_m, fa_m, fb_m, ma_m, mb_m;
    logic signed [SUM_W-1:0] abba, baba, fa, fb, ma, mb;
    logic [15:0] fill_inc;
    logic close_w;

    assign pdv = (p2_reg > p3_reg) ? p2_reg : p3_reg;
    assign qv  = (p1_reg > p3_reg) ? p1_reg : p3_reg;
    assign n1 = ONE - p1_reg;
    assign n2 = ONE - p2_reg;
    assign npd = ONE - pdv;
    assign nq = ONE - qv;

    assign done = (state_reg == BK_ACC) ||
        (state_reg == BK_IDLE && q_valid && q_cls != CLS_USED);
    assign q_ready = (state_reg == BK_IDLE) && (!out_valid_reg || m_ready);
    assign accept = q_valid && q_ready;
    assign set_out = (accept && q_cls != CLS_USED) ||
        (state_reg == BK_ACC && state_next == BK_IDLE);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (accept && q_cls == CLS_USED) state_next = BK_MUL1;
            BK_MUL1: state_next = BK_MUL2;
            BK_MUL2: state_next = BK_ACC;
            BK_ACC:  if (!out_valid_reg || m_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        abba_m = pa_reg * $signed({1'b0, p3_reg});
        baba_m = pb_reg * $signed({1'b0, p3_reg});
        fa_m = pc_reg * $signed({1'b0, pdv});
        fb_m = pd2_reg * $signed({1'b0, pdv});
        ma_m = pe_reg * $signed({1'b0, qv});
        mb_m = pf_reg * $signed({1'b0, qv});
        abba = SUM_W'(abba_m);
        baba = SUM_W'(baba_m);
        fa = SUM_W'(fa_m);
        fb = SUM_W'(fb_m);
        ma = SUM_W'(ma_m);
        mb = SUM_W'(mb_m);
    end

    assign fill_inc = (fill_reg != 16'hFFFF) ? fill_reg + 16'd1 : fill_reg;
    assign close_w = (fill_inc >= window_size);

    always_comb begin
        for (int i = 0; i < 4; i++) nw[i] = sat_add(win_reg[i], (i == 0) ? t_dn_reg :
            (i == 1) ? t_dd_reg : (i == 2) ? t_fd_reg : t_fm_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            out_valid_reg <= 1'b0;
            used_count_reg <= '0;
            fill_reg <= '0;
            wchrom_reg <= '0;
            for (int i = 0; i < 4; i++) win_reg[i] <= '0;
            for (int i = 0; i < 6; i++) tot_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (set_out) out_valid_reg <= 1'b1;
            else if (m_valid && m_ready) out_valid_reg <= 1'b0;
            if (accept) begin
                p1_reg <= q_p1;
                p2_reg <= q_p2;
                p3_reg <= q_p3;
                cls_reg <= q_cls;
                chrom_reg <= q_chrom;
                if (q_cls != CLS_USED) begin
                    o_cls_reg <= q_cls;
                    o_ev_reg <= EV_NONE;
                    for (int i = 0; i < 4; i++) o_win_reg[i] <= '0;
                end
            end
            if (state_reg == BK_MUL1) begin
                pa_reg <= PW'(n1 * p2_reg);
                pb_reg <= PW'(p1_reg * n2);
                pc_reg <= PW'(n1 * pdv);
                pd2_reg <= PW'(p1_reg * npd);
                pe_reg <= PW'(nq * p2_reg);
                pf_reg <= PW'(qv * n2);
            end
            if (state_reg == BK_MUL2) begin
                t_dn_reg <= abba - baba;
                t_dd_reg <= abba + baba;
                t_fd_reg <= fa - fb;
                t_fm_reg <= (p1_reg <= p2_reg) ? fa - fb : mb - ma;
            end
            if (state_reg == BK_ACC && state_next == BK_IDLE) begin
                o_cls_reg <= cls_reg;
                tot_reg[0] <= sat_add(tot_reg[0], t_dn_reg);
                tot_reg[1] <= sat_add(tot_reg[1], t_dd_reg);
                tot_reg[2] <= sat_add(tot_reg[2], t_fd_reg);
                tot_reg[3] <= sat_add(tot_reg[3], t_fm_reg);
                if (p3_reg == ONE) begin
                    tot_reg[4] <= sat_add(tot_reg[4], t_dn_reg);
                    tot_reg[5] <= sat_add(tot_reg[5],
                        SUM_W'({1'b0, n1}) << (2 * FREQ_FRAC_BITS));
                end
                used_count_reg <= used_count_reg + 32'd1;
                if (close_w) begin
                    o_ev_reg <= (chrom_reg == wchrom_reg) ? EV_EMIT : EV_DISCARD;
                    for (int i = 0; i < 4; i++) begin
                        o_win_reg[i] <= nw[i];
                        win_reg[i] <= '0;
                    end
                    fill_reg <= '0;
                    wchrom_reg <= chrom_reg;
                end else begin
                    o_ev_reg <= EV_NONE;
                    for (int i = 0; i < 4; i++) begin
                        o_win_reg[i] <= '0;
                        win_reg[i] <= nw[i];
                    end
                    fill_reg <= fill_inc;
                end
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_site_class = o_cls_reg;
    assign m_window_event = o_ev_reg;
    assign m_win_d_num = o_win_reg[0];
    assign m_win_d_den = o_win_reg[1][62:0];
    assign m_win_fd_den = o_win_reg[2];
    assign m_win_fdm_den = o_win_reg[3];
    assign m_tot_d_num = tot_reg[0];
    assign m_tot_d_den = tot_reg[1][62:0];
    assign m_tot_fd_den = tot_reg[2];
    assign m_tot_fdm_den = tot_reg[3];
    assign m_tot_fg_num = tot_reg[4];
    assign m_tot_fg_den = tot_reg[5][62:0];

    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_MUL1) |=> (state_reg == BK_MUL2))
        else $error("multiply sequence broken");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != BK_IDLE) |-> !q_ready)
        else $error("queue popped while busy");
    a_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_MUL1) |-> (cls_reg == CLS_USED))
        else $error("non-used site entered arithmetic");
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done && !(state_reg == BK_ACC && !(!out_valid_reg || m_ready)) |=> m_valid)
        else $error("finished site produced no result");
endmodule

>>> rtl/core/abba_baba_window_accumulator.sv
// Top level of the ABBA-BABA window accumulator.
// A site word is classified and written into a two-entry queue; a used site then passes through
// the back-end states MUL1 and MUL2 (two multiply steps) and ACC (accumulate, held until the
// output slot is free), while other sites set their result when accepted; the back end takes no
// new site until a used site has left ACC. Sums saturate at the signed 64-bit limits.
module abba_baba_window_accumulator import abba_pkg::*; #(
    parameter int FREQ_FRAC_BITS = 12,
    parameter int CHROM_WIDTH    = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [12:0]         s_p1_freq,
    input  logic [12:0]         s_p2_freq,
    input  logic [12:0]         s_p3_freq,
    input  logic                s_no_info,
    input  logic                s_is_indel,
    input  logic [15:0]         s_chrom_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_site_class,
    output logic [1:0]          m_window_event,
    output logic signed [63:0]  m_win_d_num,
    output logic [62:0]         m_win_d_den,
    output logic signed [63:0]  m_win_fd_den,
    output logic signed [63:0]  m_win_fdm_den,
    output logic signed [63:0]  m_tot_d_num,
    output logic [62:0]         m_tot_d_den,
    output logic signed [63:0]  m_tot_fd_den,
    output logic signed [63:0]  m_tot_fdm_den,
    output logic signed [63:0]  m_tot_fg_num,
    output logic [62:0]         m_tot_fg_den
);
    logic [15:0] wsize_reg;
    logic q_valid, q_ready;
    logic [FREQ_FRAC_BITS:0] q_p1, q_p2, q_p3;
    site_class_t q_cls;
    logic [CHROM_WIDTH-1:0] q_chrom;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wsize_reg <= 16'd50;
        end else if (cfg_we) begin
            wsize_reg <= cfg_wdata;
        end
    end

    abba_front #(.FREQ_FRAC_BITS(FREQ_FRAC_BITS), .CHROM_WIDTH(CHROM_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_p1_freq(s_p1_freq), .s_p2_freq(s_p2_freq), .s_p3_freq(s_p3_freq),
        .s_no_info(s_no_info), .s_is_indel(s_is_indel), .s_chrom_id(s_chrom_id),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_p1(q_p1), .q_p2(q_p2), .q_p3(q_p3), .q_cls(q_cls), .q_chrom(q_chrom)
    );

    abba_back #(.FREQ_FRAC_BITS(FREQ_FRAC_BITS), .CHROM_WIDTH(CHROM_WIDTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .window_size(wsize_reg),
        .q_valid(q_valid), .q_ready(q_ready),
        .q_p1(q_p1), .q_p2(q_p2), .q_p3(q_p3), .q_cls(q_cls), .q_chrom(q_chrom),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_site_class(m_site_class), .m_window_event(m_window_event),
        .m_win_d_num(m_win_d_num), .m_win_d_den(m_win_d_den),
        .m_win_fd_den(m_win_fd_den), .m_win_fdm_den(m_win_fdm_den),
        .m_tot_d_num(m_tot_d_num), .m_tot_d_den(m_tot_d_den),
        .m_tot_fd_den(m_tot_fd_den), .m_tot_fdm_den(m_tot_fdm_den),
        .m_tot_fg_num(m_tot_fg_num), .m_tot_fg_den(m_tot_fg_den)
    );
endmodule
